// ----- src/sha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// shared types and constants of the byte-stream sha-256 hash unit
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic logic [31:0] initial_hash(input logic [2:0] i);
    logic [31:0] r;
    begin
      case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] t);
    logic [31:0] k [64];
    begin
      k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/sha_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha_front
// accepts input transactions and drops those that carry neither byte nor end
// into a two-entry queue toward the compression engine
// ----------------------------------------------------------------------------
module sha_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sha_pkg::in_item_t in_data_i,
  output logic                   q_valid_o,
  input  wire logic              q_pop_i,
  output sha_pkg::in_item_t      q_data_o
);

  sha_pkg::in_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop, useful;

  assign useful     = in_data_i.byte_present | in_data_i.end_of_message;
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o & useful;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i & q_valid_o;
  assign q_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif

endmodule
`default_nettype wire

// ----- src/sha_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha_back
// packs bytes into the schedule window, pads, runs one round per cycle and
// emits the eight digest words
// ----------------------------------------------------------------------------
module sha_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  output logic                    q_pop_o,
  input  wire sha_pkg::in_item_t  q_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sha_pkg::out_item_t      out_data_o
);

  typedef enum logic [2:0] {
    S_TAKE, S_PAD, S_LEN, S_ROUND, S_FOLD, S_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [60:0] count_q;
  logic [5:0]  pos_q;
  logic [5:0]  rnd_q;
  logic [2:0]  len_q, emit_q;
  logic        fin_q, padded_q;
  logic        ret_q;       // state to return to after fold: 0 take, 1 pad
  logic [63:0] bits;
  logic [7:0]  ld_byte;
  logic        ld_en;
  logic [31:0] w15, w2, w7, w16, wnew, wt, s0, s1, ch, maj, t1, t2;
  logic [31:0] a, b, c, d, e, f, g, h;

  assign bits = {count_q, 3'b000};

  always_comb begin
    ld_en   = 1'b0;
    ld_byte = 8'h00;
    q_pop_o = 1'b0;
    case (state_q)
      S_TAKE: begin
        q_pop_o = q_valid_i & ~fin_q;
        ld_en   = q_valid_i & ~fin_q & q_data_i.byte_present;
        ld_byte = q_data_i.message_byte;
      end
      S_PAD: begin
        ld_en   = 1'b1;
        ld_byte = padded_q ? 8'h00 : sha_pkg::PadByte;
      end
      S_LEN: begin
        ld_en   = 1'b1;
        ld_byte = bits[63 - 8 * len_q -: 8];
      end
      default: ;
    endcase
  end

  assign {a, b, c, d, e, f, g, h} = {v_q[0], v_q[1], v_q[2], v_q[3],
                                     v_q[4], v_q[5], v_q[6], v_q[7]};
  assign w15  = w_q[rnd_q[3:0] + 4'd1];
  assign w2   = w_q[rnd_q[3:0] + 4'd14];
  assign w7   = w_q[rnd_q[3:0] + 4'd9];
  assign w16  = w_q[rnd_q[3:0]];
  assign wnew = w16 + ({w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3))
              + w7 + ({w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10));
  assign wt   = (rnd_q[5:4] == 2'd0) ? w16 : wnew;
  assign s1   = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch   = (e & f) ^ (~e & g);
  assign t1   = h + s1 + ch + sha_pkg::round_const(rnd_q) + wt;
  assign s0   = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign maj  = (a & b) ^ (a & c) ^ (b & c);
  assign t2   = s0 + maj;

  assign out_valid_o            = (state_q == S_EMIT);
  assign out_data_o.digest_word = h_q[emit_q];
  assign out_data_o.word_index  = emit_q;
  assign out_data_o.last_word   = (emit_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (ld_en) begin
      if (pos_q[1:0] == 2'd0)
        w_q[pos_q[5:2]] <= {ld_byte, 24'h0};
      else
        w_q[pos_q[5:2]] <= w_q[pos_q[5:2]] | ({24'h0, ld_byte} << (8 * (3 - pos_q[1:0])));
    end
    if (state_q == S_ROUND) w_q[rnd_q[3:0]] <= wt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_TAKE;
      count_q  <= '0;
      pos_q    <= '0;
      rnd_q    <= '0;
      len_q    <= '0;
      emit_q   <= '0;
      fin_q    <= 1'b0;
      padded_q <= 1'b0;
      ret_q    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::initial_hash(3'(i));
        v_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_TAKE: begin
          if (fin_q) begin
            state_q <= S_PAD;
          end else if (q_valid_i) begin
            if (q_data_i.byte_present) begin
              count_q <= count_q + 61'd1;
              pos_q   <= pos_q + 6'd1;
            end
            fin_q <= q_data_i.end_of_message;
            if (q_data_i.byte_present && pos_q == 6'd63) begin
              state_q <= S_ROUND;
              ret_q   <= q_data_i.end_of_message;
              for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            end else if (q_data_i.end_of_message) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          padded_q <= 1'b1;
          pos_q    <= pos_q + 6'd1;
          if (pos_q == 6'd63) begin
            state_q <= S_ROUND;
            ret_q   <= 1'b1;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          end else if (pos_q + 6'd1 == sha_pkg::LenPos) begin
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          pos_q <= pos_q + 6'd1;
          if (len_q == 3'd7) begin
            // len_q stays on the last index so the fold step sees the length in
            state_q <= S_ROUND;
            ret_q   <= 1'b1;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          end else begin
            len_q <= len_q + 3'd1;
          end
        end
        S_ROUND: begin
          v_q[0] <= t1 + t2; v_q[1] <= a; v_q[2] <= b; v_q[3] <= c;
          v_q[4] <= d + t1;  v_q[5] <= e; v_q[6] <= f; v_q[7] <= g;
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (len_q != 3'd0) begin
            state_q <= S_EMIT;
          end else begin
            // block done during data or padding
            state_q <= ret_q ? S_PAD : S_TAKE;
            fin_q   <= 1'b0;
          end
        end
        S_EMIT: begin
          if (!out_stall_i) begin
            emit_q <= emit_q + 3'd1;
            if (emit_q == 3'd7) begin
              state_q  <= S_TAKE;
              count_q  <= '0;
              len_q    <= '0;
              fin_q    <= 1'b0;
              padded_q <= 1'b0;
              for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::initial_hash(3'(i));
            end
          end
        end
        default: state_q <= S_TAKE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(emit_q))
    else $error("digest word moved under stall");
  a_round_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FOLD |-> rnd_q == 6'd0) else $error("round count off");
  a_emit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pos_q == 6'd0) else $error("digest before block end");
`endif

endmodule
`default_nettype wire

// ----- src/sha256_byte_stream_hash_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hash_unit
// byte-serial sha-256 with padding and word-serial digest output
// ----------------------------------------------------------------------------
// One byte transaction is absorbed per cycle in the take state; every 64th
// byte starts 64 compression rounds plus a fold step, so a long message is
// limited by the one round unit. An end transaction adds the padding and length
// bytes and one or two more block compressions, then eight digest words leave
// one per unstalled cycle, last_word on the eighth. Transactions with neither
// byte nor end are taken and dropped. A two-entry queue takes two more
// transactions while the round unit is busy, after which the input stalls.
module sha256_byte_stream_hash_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sha_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sha_pkg::out_item_t      out_data_o
);

  logic              q_valid, q_pop;
  sha_pkg::in_item_t q_data;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  sha_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
`default_nettype wire

// ----- test/sha256_digest_checker.sv -----
// ----------------------------------------------------------------------------
// sha256_digest_checker
// watches both channels, hashes accepted bytes and compares digest words
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire sha_pkg::in_item_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire sha_pkg::out_item_t out_data_i,
  output int                      fail_count_o,
  output int                      pending_words_o
);

  logic [31:0]        hash_state [8];
  logic [7:0]         block_bytes [64];
  logic [60:0]        msg_bytes;
  sha_pkg::out_item_t digest_fifo [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // runs the 64 rounds on block_bytes and folds into hash_state
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_const(t[5:0]) + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic absorb(input logic [7:0] b, input logic [5:0] pos);
    block_bytes[pos] = b;
    if (pos == 6'd63) compress();
  endtask

  task automatic take_item(input sha_pkg::in_item_t it);
    logic [5:0]         pos;
    logic [63:0]        bit_len;
    sha_pkg::out_item_t ow;
    if (it.byte_present) begin
      absorb(it.message_byte, msg_bytes[5:0]);
      msg_bytes = msg_bytes + 61'd1;
    end
    if (it.end_of_message) begin
      pos = msg_bytes[5:0];
      absorb(sha_pkg::PadByte, pos);
      pos = pos + 6'd1;
      while (pos != sha_pkg::LenPos) begin
        absorb(8'h00, pos);
        pos = pos + 6'd1;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) absorb(bit_len[63-8*i -: 8], sha_pkg::LenPos + i[5:0]);
      for (int i = 0; i < 8; i++) begin
        ow.digest_word = hash_state[i];
        ow.word_index  = i[2:0];
        ow.last_word   = (i == 7);
        digest_fifo = {digest_fifo, ow};
      end
      for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::initial_hash(i[2:0]);
      msg_bytes = '0;
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::initial_hash(i[2:0]);
    msg_bytes = '0;
    fail_count_o = 0;
    pending_words_o = 0;
  end

  always @(posedge clk_i) begin
    sha_pkg::out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) take_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_fifo.size() == 0) begin
          $error("unexpected digest word %h", out_data_i.digest_word);
          fail_count_o++;
        end else begin
          want = digest_fifo.pop_front();
          if (out_data_i.digest_word !== want.digest_word) begin
            $error("digest_word expected %h got %h", want.digest_word, out_data_i.digest_word);
            fail_count_o++;
          end
          if (out_data_i.word_index !== want.word_index) begin
            $error("word_index expected %0d got %0d", want.word_index, out_data_i.word_index);
            fail_count_o++;
          end
          if (out_data_i.last_word !== want.last_word) begin
            $error("last_word expected %0d got %0d", want.last_word, out_data_i.last_word);
            fail_count_o++;
          end
        end
      end
      pending_words_o = digest_fifo.size();
    end
  end
endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives byte messages into the sha-256 unit under varying idle and stall
// ----------------------------------------------------------------------------
module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sha_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sha_pkg::out_item_t out_data;
  int                 fail_count, pending_words;
  int                 send_idle_pct = 0, stall_pct = 0;
  bit                 hold_off = 1'b0;

  always #6 clk = ~clk;

  sha256_byte_stream_hash_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sha256_digest_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_words_o(pending_words)
  );

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // valid stays up after the accepting edge until a later idle draw or the caller drops it
  task automatic send(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{message_byte: b, byte_present: present, end_of_message: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input bit random_bytes);
    for (int i = 0; i < len; i++) begin
      send(random_bytes ? 8'($urandom) : 8'(i), 1'b1, 1'b0);
      if ($urandom_range(9) == 0) send(8'($urandom), 1'b0, 1'b0);
    end
    if ($urandom_range(1)) send(8'($urandom), 1'b0, 1'b1);
    else send(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic set_phase(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty message, twice in a row, a dropped empty transaction, then extreme bytes
    send(8'hff, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b0);
    send(8'hff, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'h55, 1'b1, 1'b1);
    send(8'haa, 1'b1, 1'b1);

    // long hold-off while the sender keeps offering a message near the block end
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(0, 1'b1);
        send_message(63, 1'b1);
        in_valid <= 1'b0;
        @(negedge clk);
      end
    join

    // random phases with short messages
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_phase(0, 0);
        1: set_phase(59, 0);
        2: set_phase(0, 59);
        default: set_phase(11, 11);
      endcase
      for (int m = 0; m < 2; m++) begin
        send_message($urandom_range(4), 1'b1);
      end
    end
    in_valid <= 1'b0;
    set_phase(0, 0);

    while (pending_words != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end
endmodule
